FILE: design/sssr_pkg.sv
// Shared types, widths and constants for the three-axis setpoint slew ramp.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package sssr_pkg;

  // Field and datapath widths
  localparam int POS_W   = 28;   // position reference / target, signed um
  localparam int SPD_W   = 24;   // speed limit, um/s
  localparam int TIME_W  = 32;   // elapsed time and start times, us
  localparam int GAP_W   = 24;   // raw tick gap, us
  localparam int DT_W    = 20;   // effective step time, covers 1e6/1 Hz
  localparam int PROD_W  = SPD_W + DT_W;          // speed * dt
  localparam int PRE_SHIFT = 6;                   // 1e6 = 2^6 * 15625
  localparam int XQ_W    = PROD_W - PRE_SHIFT;    // dividend for the odd part
  localparam int STEP_W  = 24;   // step per tick, never above the speed
  localparam int LO_W    = 19;   // low slice of the dividend
  localparam int HI_W    = XQ_W - LO_W;
  localparam int REC_W   = 25;
  localparam int PART_W  = HI_W + REC_W;
  localparam int EST_W   = 64;
  localparam int REC_SHIFT = 38;

  // floor(2^38 / 15625): the estimate is low by at most one
  localparam logic [REC_W-1:0] REC_MUL = 25'd17592186;
  localparam int DIV_ODD = 15625;

  localparam int US_PER_S   = 1000000;
  localparam int MAX_GAP_US = 100000;
  localparam int TICK_RATE_HZ_DEF = 200;

  localparam int NUM_AXES = 3;
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Register reset values
  localparam logic [POS_W-1:0]  TARGET_X_RST  = 28'd0;
  localparam logic [POS_W-1:0]  TARGET_Y_RST  = 28'd0;
  localparam logic [POS_W-1:0]  TARGET_Z_RST  = 28'd1000000;
  localparam logic [SPD_W-1:0]  SPEED_X_RST   = 24'd100000;
  localparam logic [SPD_W-1:0]  SPEED_Y_RST   = 24'd100000;
  localparam logic [SPD_W-1:0]  SPEED_Z_RST   = 24'd300000;
  localparam logic [TIME_W-1:0] APPROACH_RST  = 32'd5000000;
  localparam logic [TIME_W-1:0] LATERAL_RST   = 32'd10000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X,
    REG_TARGET_Y,
    REG_TARGET_Z,
    REG_SPEED_X,
    REG_SPEED_Y,
    REG_SPEED_Z,
    REG_APPROACH_START,
    REG_LATERAL_START
  } cfg_reg_t;

  typedef struct packed {
    logic sel_x;   // x target active
    logic sel_y;   // y target active
  } tgt_sel_t;

  typedef struct packed {
    tgt_sel_t         sel;
    logic [DT_W-1:0]  dt;
  } tick_ctrl_t;

endpackage

FILE: design/three_axis_setpoint_slew_ramp.sv
// Three-axis setpoint slew ramp: top level with configuration registers.
// Path of a tick: input register, control stage, five step-size stages and
// the slew/result register. Throughput: one tick per cycle unless the output stalls;
// ticks that leave the block disabled give no result.
// Reset (rst, synchronous, active high) disables the block, clears elapsed time,
// sets references to x=0, y=0, z=1000000 and loads register defaults.
`timescale 1ns / 1ps

module three_axis_setpoint_slew_ramp #(
  parameter int TICK_RATE_HZ = sssr_pkg::TICK_RATE_HZ_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Tick input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [23:0] tick_gap_us, [24] toggle_enable, [31:25] zero
  input  logic [sssr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Reference output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [27:0] ref_x_um, [55:28] ref_y_um, [83:56] ref_z_um, [87:84] zero
  output logic [sssr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [sssr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sssr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sssr_pkg::*;

  // Configuration registers
  logic signed [POS_W-1:0] x_goal;
  logic signed [POS_W-1:0] y_goal;
  logic signed [POS_W-1:0] z_goal;
  logic [SPD_W-1:0]        speed_x;
  logic [SPD_W-1:0]        speed_y;
  logic [SPD_W-1:0]        speed_z;
  logic [TIME_W-1:0]       approach_start;
  logic [TIME_W-1:0]       lateral_start;

  // Stage handshakes
  logic       ctrl_valid;
  logic       ctrl_ready;
  tick_ctrl_t ctrl;
  logic       step_valid;
  logic       step_ready;
  tgt_sel_t   step_sel;
  logic [NUM_AXES-1:0][STEP_W-1:0] step;
  logic [NUM_AXES-1:0][SPD_W-1:0]  speed;

  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  // Register writes land at once; the user must confine them to idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_goal         <= TARGET_X_RST;
      y_goal         <= TARGET_Y_RST;
      z_goal         <= TARGET_Z_RST;
      speed_x        <= SPEED_X_RST;
      speed_y        <= SPEED_Y_RST;
      speed_z        <= SPEED_Z_RST;
      approach_start <= APPROACH_RST;
      lateral_start  <= LATERAL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_X:       x_goal         <= cfg_data[POS_W-1:0];
        REG_TARGET_Y:       y_goal         <= cfg_data[POS_W-1:0];
        REG_TARGET_Z:       z_goal         <= cfg_data[POS_W-1:0];
        REG_SPEED_X:        speed_x        <= cfg_data[SPD_W-1:0];
        REG_SPEED_Y:        speed_y        <= cfg_data[SPD_W-1:0];
        REG_SPEED_Z:        speed_z        <= cfg_data[SPD_W-1:0];
        REG_APPROACH_START: approach_start <= cfg_data[TIME_W-1:0];
        REG_LATERAL_START:  lateral_start  <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign speed[AXIS_X] = speed_x;
  assign speed[AXIS_Y] = speed_y;
  assign speed[AXIS_Z] = speed_z;

  // Front end: take the tick, flip enable, advance elapsed time, pick dt
  // and which targets are live. Disabled ticks are dropped here.
  sssr_ctrl #(
    .TICK_RATE_HZ (TICK_RATE_HZ)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .gap            (s_axis_tdata[GAP_W-1:0]),
    .toggle         (s_axis_tdata[GAP_W]),
    .approach_start (approach_start),
    .lateral_start  (lateral_start),
    .out_valid      (ctrl_valid),
    .out_ready      (ctrl_ready),
    .out_ctrl       (ctrl)
  );

  // Per-axis step size, floor(speed * dt / 1e6), over five stages.
  sssr_step u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ctrl_valid),
    .in_ready  (ctrl_ready),
    .in_ctrl   (ctrl),
    .speed     (speed),
    .out_valid (step_valid),
    .out_ready (step_ready),
    .out_sel   (step_sel),
    .out_step  (step)
  );

  // Slew each reference toward its target; the reference registers are
  // the result register, held while the downstream stalls.
  sssr_slew u_slew (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (step_valid),
    .in_ready  (step_ready),
    .in_sel    (step_sel),
    .in_step   (step),
    .x_goal    (x_goal),
    .y_goal    (y_goal),
    .z_goal    (z_goal),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - NUM_AXES*POS_W)'(0), pos_z, pos_y, pos_x};

endmodule

FILE: design/sssr_ctrl.sv
// Tick front end: input register, enable toggle, elapsed-time counter,
// step time and target selection. Depends on sssr_pkg.
`timescale 1ns / 1ps

module sssr_ctrl #(
  parameter int TICK_RATE_HZ = sssr_pkg::TICK_RATE_HZ_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sssr_pkg::GAP_W-1:0]    gap,
  input  logic                          toggle,
  input  logic [sssr_pkg::TIME_W-1:0]   approach_start,
  input  logic [sssr_pkg::TIME_W-1:0]   lateral_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sssr_pkg::tick_ctrl_t          out_ctrl
);
  import sssr_pkg::*;

  localparam logic [DT_W-1:0] DEFAULT_DT = DT_W'(US_PER_S / TICK_RATE_HZ);

  logic              v0;
  logic [GAP_W-1:0]  gap0;
  logic              tog0;
  logic              rdy0;
  logic              rdy1;

  logic              run_en;
  logic              run_en_next;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] elapsed_next;
  logic [TIME_W:0]   elapsed_sum;
  logic [TIME_W-1:0] y_start;
  logic              just_en;
  tick_ctrl_t        ctrl_next;

  assign rdy1     = !out_valid || out_ready;
  assign rdy0     = !v0 || rdy1;
  assign in_ready = rdy0;

  always_comb begin
    run_en_next = run_en ^ tog0;
    just_en     = tog0 && !run_en;
    elapsed_sum = {1'b0, elapsed} + (TIME_W+1)'(gap0);
    if (!run_en_next) begin
      elapsed_next = elapsed;
    end else if (just_en) begin
      elapsed_next = '0;
    end else if (elapsed_sum[TIME_W]) begin
      elapsed_next = '1;
    end else begin
      elapsed_next = elapsed_sum[TIME_W-1:0];
    end

    if (just_en || gap0 == '0 || gap0 > GAP_W'(MAX_GAP_US)) begin
      ctrl_next.dt = DEFAULT_DT;
    end else begin
      ctrl_next.dt = gap0[DT_W-1:0];
    end

    y_start = (lateral_start > approach_start) ? lateral_start : approach_start;
    ctrl_next.sel.sel_x = elapsed_next >= approach_start;
    ctrl_next.sel.sel_y = elapsed_next >= y_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      out_valid <= 1'b0;
      run_en    <= 1'b0;
      elapsed   <= '0;
    end else begin
      if (rdy0) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        out_valid <= v0 && run_en_next;
        if (v0) begin
          run_en  <= run_en_next;
          elapsed <= elapsed_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      gap0 <= gap;
      tog0 <= toggle;
    end
    if (rdy1) begin
      out_ctrl <= ctrl_next;
    end
  end

endmodule

FILE: design/sssr_step.sv
// Step-size pipeline: floor(speed * dt / 1e6) for all three axes in five
// registered stages (product, split reciprocal, estimate, back-multiply, fix).
// Depends on sssr_pkg.
`timescale 1ns / 1ps

module sssr_step (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  sssr_pkg::tick_ctrl_t                              in_ctrl,
  input  logic [sssr_pkg::NUM_AXES-1:0][sssr_pkg::SPD_W-1:0] speed,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output sssr_pkg::tgt_sel_t                                out_sel,
  output logic [sssr_pkg::NUM_AXES-1:0][sssr_pkg::STEP_W-1:0] out_step
);
  import sssr_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  tgt_sel_t        sel [NSTG];

  logic [NUM_AXES-1:0][PROD_W-1:0] prod;
  logic [NUM_AXES-1:0][PART_W-1:0] part_hi;
  logic [NUM_AXES-1:0][PART_W-1:0] part_lo;
  logic [NUM_AXES-1:0][XQ_W-1:0]   x2;
  logic [NUM_AXES-1:0][XQ_W-1:0]   x3;
  logic [NUM_AXES-1:0][XQ_W-1:0]   x4;
  logic [NUM_AXES-1:0][STEP_W-1:0] q3;
  logic [NUM_AXES-1:0][STEP_W-1:0] q4;
  logic [NUM_AXES-1:0][XQ_W-1:0]   qm4;

  logic [NUM_AXES-1:0][XQ_W-1:0]   x_w;
  logic [NUM_AXES-1:0][EST_W-1:0]  est_w;
  logic [NUM_AXES-1:0][XQ_W-1:0]   rem_w;

  assign rdy[NSTG] = out_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld[NSTG-1];
  assign out_sel   = sel[NSTG-1];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      x_w[a]   = prod[a][PROD_W-1:PRE_SHIFT];
      est_w[a] = (EST_W'(part_hi[a]) << LO_W) + EST_W'(part_lo[a]);
      rem_w[a] = x4[a] - qm4[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sel[0] <= in_ctrl.sel;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        sel[k] <= sel[k-1];
      end
    end

    for (int a = 0; a < NUM_AXES; a++) begin
      if (rdy[0]) begin
        prod[a] <= PROD_W'(speed[a]) * PROD_W'(in_ctrl.dt);
      end
      if (rdy[1]) begin
        part_hi[a] <= PART_W'(x_w[a][XQ_W-1:LO_W]) * PART_W'(REC_MUL);
        part_lo[a] <= PART_W'(x_w[a][LO_W-1:0]) * PART_W'(REC_MUL);
        x2[a]      <= x_w[a];
      end
      if (rdy[2]) begin
        q3[a] <= est_w[a][REC_SHIFT +: STEP_W];
        x3[a] <= x2[a];
      end
      if (rdy[3]) begin
        q4[a]  <= q3[a];
        qm4[a] <= XQ_W'(q3[a]) * XQ_W'(DIV_ODD);
        x4[a]  <= x3[a];
      end
      if (rdy[4]) begin
        // estimate may be one short: bump it when the remainder still holds a divisor
        out_step[a] <= q4[a] + STEP_W'(rem_w[a] >= XQ_W'(DIV_ODD));
      end
    end
  end

endmodule

FILE: design/sssr_slew.sv
// Output stage: per-axis target selection and clamped slew of the position
// references, which double as the result register. Depends on sssr_pkg.
`timescale 1ns / 1ps

module sssr_slew (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  sssr_pkg::tgt_sel_t                                  in_sel,
  input  logic [sssr_pkg::NUM_AXES-1:0][sssr_pkg::STEP_W-1:0] in_step,
  input  logic signed [sssr_pkg::POS_W-1:0]                   x_goal,
  input  logic signed [sssr_pkg::POS_W-1:0]                   y_goal,
  input  logic signed [sssr_pkg::POS_W-1:0]                   z_goal,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output logic signed [sssr_pkg::POS_W-1:0]                   pos_x,
  output logic signed [sssr_pkg::POS_W-1:0]                   pos_y,
  output logic signed [sssr_pkg::POS_W-1:0]                   pos_z
);
  import sssr_pkg::*;

  logic signed [POS_W-1:0] tgt_x;
  logic signed [POS_W-1:0] tgt_y;
  logic signed [POS_W-1:0] pos_x_next;
  logic signed [POS_W-1:0] pos_y_next;
  logic signed [POS_W-1:0] pos_z_next;

  // Move cur toward tgt by step, landing exactly on tgt when step reaches it.
  function automatic logic signed [POS_W-1:0] slew_step(
    input logic signed [POS_W-1:0] cur,
    input logic signed [POS_W-1:0] tgt,
    input logic [STEP_W-1:0]       step
  );
    logic signed [POS_W:0] diff;
    logic [POS_W:0]        mag;
    logic [POS_W:0]        step_ext;
    logic                  up;
    diff     = {tgt[POS_W-1], tgt} - {cur[POS_W-1], cur};
    up       = !diff[POS_W];
    mag      = up ? diff : -diff;
    step_ext = (POS_W+1)'(step);
    if (step_ext >= mag) begin
      slew_step = tgt;
    end else if (up) begin
      slew_step = cur + POS_W'(step);
    end else begin
      slew_step = cur - POS_W'(step);
    end
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    tgt_x      = in_sel.sel_x ? x_goal : '0;
    tgt_y      = in_sel.sel_y ? y_goal : '0;
    pos_x_next = slew_step(pos_x, tgt_x, in_step[AXIS_X]);
    pos_y_next = slew_step(pos_y, tgt_y, in_step[AXIS_Y]);
    pos_z_next = slew_step(pos_z, z_goal, in_step[AXIS_Z]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
      pos_z     <= TARGET_Z_RST;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
        pos_z <= pos_z_next;
      end
    end
  end

endmodule

FILE: design/sssr_checker.sv
// Port-level checks for the three-axis setpoint slew ramp, bound to the top.
// Depends on sssr_pkg.
`timescale 1ns / 1ps

module sssr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sssr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import sssr_pkg::*;

  // Reset empties the pipeline: no result right after a reset cycle.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // An empty result register means every stage can move, so the input is open.
  assert property (@(posedge clk) disable iff (rst) !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register is empty");

  // A stalled result holds its references.
  assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Pad bits above the z reference stay zero.
  assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:NUM_AXES*POS_W] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind three_axis_setpoint_slew_ramp sssr_checker u_sssr_checker (.*);
